// ===== src/lzwve_pkg.sv =====
// Shared types and constants of the LZW variable-width encoder.
package lzwve_pkg;

    localparam int BYTE_W         = 8;
    localparam int CLEAR_CODE     = 256;
    localparam int END_CODE       = 257;
    localparam int FIRST_FREE     = 258;
    localparam int MIN_CODE_WIDTH = 9;
    localparam int MAX_OUT        = 4;

    localparam logic ACT_DATA   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HEAD,
        S_NODE,
        S_MISS,
        S_CLRCODE,
        S_FIN,
        S_END
    } t_state;

    // Control that goes with one code handed to the bit packer.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic pad;
    } t_pack_ctl;

endpackage

// ===== src/lzw_variable_width_encoder_unit.sv =====
// Top level of the LZW variable-width encoder: dictionary sequencer and memories.
//
// Usage: the input channel (i_valid / o_ready) carries one item per transfer:
// i_action = 0 compresses i_data_byte, i_action = 1 finishes the stream. The
// output channel (o_valid / i_ready) carries packed code bytes, LSB-first,
// with o_last_of_run set on the final byte that one input item produces.
// An item is accepted, then the child head of the prefix is read, then the
// nodes on the child list are visited one at a time, and any code that the
// item emits is handed to the packer. The child-list walk goes through the
// node memory's single read port. An item that emits a code also waits
// until the packer has drained the bytes of the previous code, one byte per
// cycle while the receiver is ready.
// After reset, after every finish item and after the table runs full, the
// child-head memory is swept to zero, one entry per cycle; no input transfer
// is taken during that sweep.
// A stalled receiver holds the output register and the packer then stops sending bytes.
// The sequencer waits in its emit states until the packer can take the next
// code, and the input is not ready during that wait.
module lzw_variable_width_encoder_unit #(
    parameter int TABLE_ENTRIES  = 4096,
    parameter int MAX_CODE_WIDTH = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_action,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int NFC_W  = AW + 1;
    localparam int CWW    = $clog2(MAX_CODE_WIDTH + 1);
    localparam int NODE_W = lzwve_pkg::BYTE_W + AW;

    lzwve_pkg::t_state r_state, n_state;
    logic [AW-1:0]     r_clr_addr, n_clr_addr;
    logic [AW-1:0]     r_prefix, n_prefix;
    logic              r_prefix_valid, n_prefix_valid;
    logic [NFC_W-1:0]  r_nfc, n_nfc;
    logic [CWW-1:0]    r_cw, n_cw;
    logic [7:0]        r_sym, n_sym;
    logic [AW-1:0]     r_link, n_link;
    logic [AW-1:0]     r_head, n_head;

    // Child-head memory: first child of each code, zero meaning none.
    logic              head_we;
    logic [AW-1:0]     head_waddr;
    logic [AW-1:0]     head_wdata;
    logic [AW-1:0]     head_rdata;

    // Node memory: symbol and next-sibling link of each added code.
    logic              node_we;
    logic [AW-1:0]     node_raddr;
    logic [NODE_W-1:0] node_wdata;
    logic [NODE_W-1:0] node_rdata;
    logic [7:0]        node_sym;
    logic [AW-1:0]     node_sib;

    lzwve_pkg::t_pack_ctl pk_ctl;
    logic [AW-1:0]     pk_code;
    logic              pk_ready;

    logic              table_full;
    logic [NFC_W-1:0]  grow_point;

    assign node_sym   = node_rdata[NODE_W-1:AW];
    assign node_sib   = node_rdata[AW-1:0];
    assign table_full = r_nfc >= NFC_W'(TABLE_ENTRIES);
    assign grow_point = NFC_W'(1) << r_cw;
    assign node_raddr = (r_state == lzwve_pkg::S_HEAD) ? head_rdata : node_sib;

    lzwve_ram #(
        .WIDTH (AW),
        .DEPTH (TABLE_ENTRIES)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (r_prefix),
        .o_rdata (head_rdata)
    );

    lzwve_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (r_nfc[AW-1:0]),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    lzwve_packer #(
        .CODE_W         (AW),
        .CWW            (CWW),
        .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
    ) u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (pk_ctl),
        .i_code        (pk_code),
        .i_width       (r_cw),
        .o_ready       (pk_ready),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_nfc          = r_nfc;
        n_cw           = r_cw;
        n_sym          = r_sym;
        n_link         = r_link;
        n_head         = r_head;

        head_we    = 1'b0;
        head_waddr = r_prefix;
        head_wdata = '0;
        node_we    = 1'b0;
        node_wdata = {r_sym, r_head};
        pk_ctl     = '0;
        pk_code    = r_prefix;
        o_ready    = (r_state == lzwve_pkg::S_IDLE);

        case (r_state)
            lzwve_pkg::S_CLEAR: begin
                // Sweep the child heads back to "no child".
                head_we    = 1'b1;
                head_waddr = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_ENTRIES - 1)) begin
                    n_clr_addr = '0;
                    n_state    = lzwve_pkg::S_IDLE;
                end
            end
            lzwve_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_sym = i_data_byte;
                    if (i_action == lzwve_pkg::ACT_FINISH) begin
                        n_state = lzwve_pkg::S_FIN;
                    end else if (!r_prefix_valid) begin
                        // First byte of a stream only becomes the prefix.
                        n_prefix       = AW'(i_data_byte);
                        n_prefix_valid = 1'b1;
                    end else begin
                        n_state = lzwve_pkg::S_HEAD;
                    end
                end
            end
            lzwve_pkg::S_HEAD: begin
                n_head = head_rdata;
                n_link = head_rdata;
                if (head_rdata == '0) begin
                    n_state = lzwve_pkg::S_MISS;
                end else begin
                    n_state = lzwve_pkg::S_NODE;
                end
            end
            lzwve_pkg::S_NODE: begin
                if (node_sym == r_sym) begin
                    n_prefix = r_link;
                    n_state  = lzwve_pkg::S_IDLE;
                end else if (node_sib == '0) begin
                    n_state = lzwve_pkg::S_MISS;
                end else begin
                    n_link = node_sib;
                end
            end
            lzwve_pkg::S_MISS: begin
                if (pk_ready) begin
                    pk_ctl.valid = 1'b1;
                    pk_ctl.first = 1'b1;
                    pk_ctl.last  = !table_full;
                    if (table_full) begin
                        n_state = lzwve_pkg::S_CLRCODE;
                    end else begin
                        // Link the new string in front of the prefix's children.
                        node_we    = 1'b1;
                        head_we    = 1'b1;
                        head_wdata = r_nfc[AW-1:0];
                        n_nfc      = r_nfc + NFC_W'(1);
                        if ((r_nfc == grow_point) && (r_cw < CWW'(MAX_CODE_WIDTH))) begin
                            n_cw = r_cw + CWW'(1);
                        end
                        n_prefix = AW'(r_sym);
                        n_state  = lzwve_pkg::S_IDLE;
                    end
                end
            end
            lzwve_pkg::S_CLRCODE: begin
                pk_code = AW'(lzwve_pkg::CLEAR_CODE);
                if (pk_ready) begin
                    pk_ctl.valid   = 1'b1;
                    pk_ctl.last    = 1'b1;
                    n_nfc          = NFC_W'(lzwve_pkg::FIRST_FREE);
                    n_cw           = CWW'(lzwve_pkg::MIN_CODE_WIDTH);
                    n_prefix       = AW'(r_sym);
                    n_prefix_valid = 1'b1;
                    n_state        = lzwve_pkg::S_CLEAR;
                end
            end
            lzwve_pkg::S_FIN: begin
                if (pk_ready) begin
                    pk_ctl.valid = 1'b1;
                    pk_ctl.first = 1'b1;
                    if (r_prefix_valid) begin
                        n_state = lzwve_pkg::S_END;
                    end else begin
                        // Empty stream: the end code alone goes out.
                        pk_code        = AW'(lzwve_pkg::END_CODE);
                        pk_ctl.last    = 1'b1;
                        pk_ctl.pad     = 1'b1;
                        n_nfc          = NFC_W'(lzwve_pkg::FIRST_FREE);
                        n_cw           = CWW'(lzwve_pkg::MIN_CODE_WIDTH);
                        n_prefix       = '1;
                        n_prefix_valid = 1'b0;
                        n_state        = lzwve_pkg::S_CLEAR;
                    end
                end
            end
            lzwve_pkg::S_END: begin
                pk_code = AW'(lzwve_pkg::END_CODE);
                if (pk_ready) begin
                    pk_ctl.valid   = 1'b1;
                    pk_ctl.last    = 1'b1;
                    pk_ctl.pad     = 1'b1;
                    n_nfc          = NFC_W'(lzwve_pkg::FIRST_FREE);
                    n_cw           = CWW'(lzwve_pkg::MIN_CODE_WIDTH);
                    n_prefix       = '1;
                    n_prefix_valid = 1'b0;
                    n_state        = lzwve_pkg::S_CLEAR;
                end
            end
            default: begin
                n_state = lzwve_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= lzwve_pkg::S_CLEAR;
            r_clr_addr     <= '0;
            r_prefix       <= '1;
            r_prefix_valid <= 1'b0;
            r_nfc          <= NFC_W'(lzwve_pkg::FIRST_FREE);
            r_cw           <= CWW'(lzwve_pkg::MIN_CODE_WIDTH);
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_prefix       <= n_prefix;
            r_prefix_valid <= n_prefix_valid;
            r_nfc          <= n_nfc;
            r_cw           <= n_cw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym  <= n_sym;
        r_link <= n_link;
        r_head <= n_head;
    end

endmodule

// ===== src/lzwve_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module lzwve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/lzwve_packer.sv =====
// Bit packer: appends variable-width codes LSB-first and sends out whole bytes.
module lzwve_packer #(
    parameter int CODE_W         = 12,
    parameter int CWW            = 4,
    parameter int MAX_CODE_WIDTH = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzwve_pkg::t_pack_ctl i_ctl,
    input  logic [CODE_W-1:0]    i_code,
    input  logic [CWW-1:0]       i_width,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_of_run
);

    localparam int ACC_W = MAX_CODE_WIDTH + 7;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int BC_W  = $clog2(lzwve_pkg::MAX_OUT + 1);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BC_W-1:0]  r_bytes, n_bytes;
    logic             r_last, n_last;
    logic             r_pad, n_pad;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_byte, n_out_byte;
    logic             r_out_last, n_out_last;

    logic             slot_free;
    logic [CNT_W-1:0] rem;
    logic             pad_will;
    logic [ACC_W-1:0] mask;
    logic [ACC_W-1:0] code_ext;

    always_comb begin
        slot_free = !r_out_valid || i_ready;
        o_ready   = (r_cnt < CNT_W'(8)) && !r_pad;
        rem       = r_cnt - CNT_W'(8);
        pad_will  = r_pad && (rem != '0) && (r_bytes < BC_W'(lzwve_pkg::MAX_OUT - 1));
        mask      = ~({ACC_W{1'b1}} << i_width);
        code_ext  = ACC_W'(i_code) & mask;

        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_bytes     = r_bytes;
        n_last      = r_last;
        n_pad       = r_pad;
        n_out_valid = r_out_valid && !i_ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (i_ctl.valid && o_ready) begin
            n_acc  = r_acc | (code_ext << r_cnt[2:0]);
            n_cnt  = r_cnt + CNT_W'(i_width);
            n_last = i_ctl.last;
            n_pad  = i_ctl.pad;
            if (i_ctl.first) begin
                n_bytes = '0;
            end
        end else if ((r_cnt >= CNT_W'(8)) && slot_free) begin
            n_out_valid = 1'b1;
            n_out_byte  = r_acc[7:0];
            n_out_last  = r_last && (rem < CNT_W'(8)) && !pad_will;
            n_acc       = r_acc >> 8;
            n_cnt       = rem;
            n_bytes     = r_bytes + BC_W'(1);
            if ((rem < CNT_W'(8)) && r_pad && !pad_will) begin
                n_pad = 1'b0;
            end
        end else if (r_pad && slot_free) begin
            // Final partial byte of a finished stream, zero padded.
            n_out_valid = 1'b1;
            n_out_byte  = r_acc[7:0];
            n_out_last  = 1'b1;
            n_acc       = '0;
            n_cnt       = '0;
            n_bytes     = r_bytes + BC_W'(1);
            n_pad       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_bytes     <= '0;
            r_last      <= 1'b0;
            r_pad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_bytes     <= n_bytes;
            r_last      <= n_last;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule
